// ===== design/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// shared constants and types of the nearest palette color block
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int INDEX_SPAN    = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int SEARCH_LIMIT  = (PALETTE_DEPTH < INDEX_SPAN) ? PALETTE_DEPTH : INDEX_SPAN;

  localparam int COLOR_W       = 8;
  localparam int IDX_W         = 8;
  localparam int RGB_W         = 3 * COLOR_W;
  localparam int CNT_W         = 9;
  localparam int DIST_W        = 2 * COLOR_W + 2;

  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam int CFG_AW        = 3;
  localparam logic REG_ACTIVE_ENTRIES = 1'b0;

  typedef logic [PAL_AW-1:0] pal_addr_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MAP   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [RGB_W-1:0]   rgb;
    logic [IDX_W-1:0]   last;
  } item_t;

endpackage

`default_nettype wire

// ===== design/npc_ram.sv =====
// ----------------------------------------------------------------------------
// npc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module npc_ram #(
  parameter int W = 24,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/npc_front.sv =====
// ----------------------------------------------------------------------------
// npc_front
// accepts items, decodes write and map, snapshots the search count,
// holds the configuration register
// ----------------------------------------------------------------------------
`default_nettype none

module npc_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [npc_pkg::IDX_W-1:0]      in_entry_index,
  input  wire logic [npc_pkg::COLOR_W-1:0]    in_red,
  input  wire logic [npc_pkg::COLOR_W-1:0]    in_green,
  input  wire logic [npc_pkg::COLOR_W-1:0]    in_blue,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [npc_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic      [31:0]                    cfg_prdata,
  output logic                                q_push,
  output npc_pkg::item_t                      q_item,
  input  wire logic                           q_ready
);

  logic [npc_pkg::CNT_W-1:0] active_r;
  logic [npc_pkg::CNT_W-1:0] active_nxt;
  logic [npc_pkg::CNT_W-1:0] n_min;
  logic [npc_pkg::CNT_W-1:0] n_sat;
  logic                      idx_ok;
  logic                      cfg_wr;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == npc_pkg::REG_ACTIVE_ENTRIES);

  always_comb begin
    active_nxt = active_r;
    if (cfg_wr) begin
      active_nxt = cfg_pwdata[npc_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= npc_pkg::CNT_W'(256);
    end else begin
      active_r <= active_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == npc_pkg::REG_ACTIVE_ENTRIES) begin
      cfg_prdata = {{(32 - npc_pkg::CNT_W){1'b0}}, active_r};
    end
  end

  // clamp the search count to one .. limit
  always_comb begin
    n_min = (active_r == '0) ? npc_pkg::CNT_W'(1) : active_r;
    n_sat = (n_min > npc_pkg::CNT_W'(npc_pkg::SEARCH_LIMIT)) ?
            npc_pkg::CNT_W'(npc_pkg::SEARCH_LIMIT) : n_min;
  end

  // writes beyond the store are dropped
  assign idx_ok = (32'(in_entry_index) < npc_pkg::PALETTE_DEPTH);

  assign in_stall = !q_ready;

  always_comb begin
    q_item.op   = in_action ? npc_pkg::OP_MAP : npc_pkg::OP_WRITE;
    q_item.idx  = in_entry_index;
    q_item.rgb  = {in_red, in_green, in_blue};
    q_item.last = npc_pkg::IDX_W'(n_sat - npc_pkg::CNT_W'(1));
    q_push      = in_valid && q_ready && (in_action || idx_ok);
  end

endmodule

`default_nettype wire

// ===== design/npc_queue.sv =====
// ----------------------------------------------------------------------------
// npc_queue
// short fifo of decoded items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module npc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  npc_pkg::item_t      push_item,
  output logic                ready,
  output logic                head_valid,
  output npc_pkg::item_t      head_item,
  input  wire logic           pop
);

  npc_pkg::item_t                 slot_r [npc_pkg::QDEPTH];
  logic [npc_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [npc_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [npc_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [npc_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [npc_pkg::QCNT_W-1:0]     count_r;
  logic [npc_pkg::QCNT_W-1:0]     count_nxt;
  logic                           do_pop;

  assign ready      = (count_r != npc_pkg::QCNT_W'(npc_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == npc_pkg::QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == npc_pkg::QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/npc_back.sv =====
// ----------------------------------------------------------------------------
// npc_back
// executes queued items: palette writes and the nearest entry scan
// ----------------------------------------------------------------------------
`default_nettype none

module npc_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  npc_pkg::item_t                    q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [npc_pkg::COLOR_W-1:0]       out_red,
  output logic [npc_pkg::COLOR_W-1:0]       out_green,
  output logic [npc_pkg::COLOR_W-1:0]       out_blue,
  output logic [npc_pkg::IDX_W-1:0]         out_chosen_index
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                         state_r;
  state_t                         state_nxt;
  logic [npc_pkg::IDX_W-1:0]      cnt_r;
  logic [npc_pkg::IDX_W-1:0]      cnt_nxt;
  logic [npc_pkg::IDX_W-1:0]      last_r;
  logic [npc_pkg::RGB_W-1:0]      pix_r;

  logic                           ram_we;
  logic                           ram_re;
  logic [npc_pkg::RGB_W-1:0]      ram_rdata;

  logic                           p1_v_r;
  logic [npc_pkg::IDX_W-1:0]      p1_idx_r;
  logic                           p2_v_r;
  logic [npc_pkg::IDX_W-1:0]      p2_idx_r;
  logic [npc_pkg::RGB_W-1:0]      p2_rgb_r;
  logic [npc_pkg::DIST_W-1:0]     d_r;
  logic [npc_pkg::DIST_W-1:0]     d_nxt;

  logic [npc_pkg::DIST_W-1:0]     best_d_r;
  logic [npc_pkg::IDX_W-1:0]      best_idx_r;
  logic [npc_pkg::RGB_W-1:0]      best_rgb_r;
  logic                           take_best;

  logic                           out_valid_r;
  logic [npc_pkg::RGB_W-1:0]      out_rgb_r;
  logic [npc_pkg::IDX_W-1:0]      out_idx_r;
  logic                           load_out;

  logic [npc_pkg::COLOR_W-1:0]    dr;
  logic [npc_pkg::COLOR_W-1:0]    dg;
  logic [npc_pkg::COLOR_W-1:0]    db;
  logic [npc_pkg::COLOR_W-1:0]    er;
  logic [npc_pkg::COLOR_W-1:0]    eg;
  logic [npc_pkg::COLOR_W-1:0]    eb;
  logic [npc_pkg::COLOR_W-1:0]    pr;
  logic [npc_pkg::COLOR_W-1:0]    pg;
  logic [npc_pkg::COLOR_W-1:0]    pb;

  npc_ram #(
    .W (npc_pkg::RGB_W),
    .D (npc_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (npc_pkg::pal_addr_t'(q_item.idx)),
    .wdata (q_item.rgb),
    .re    (ram_re),
    .raddr (npc_pkg::pal_addr_t'(cnt_r)),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == npc_pkg::OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            state_nxt = S_SCAN;
            cnt_nxt   = '0;
          end
        end
      end
      S_SCAN: begin
        ram_re  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == last_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1_v_r && !p2_v_r && (!out_valid_r || !out_stall)) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= ram_re;
      p2_v_r  <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (q_pop && (q_item.op == npc_pkg::OP_MAP)) begin
      pix_r  <= q_item.rgb;
      last_r <= q_item.last;
    end
  end

  // squared distance of the entry just read
  always_comb begin
    {er, eg, eb} = ram_rdata;
    {pr, pg, pb} = pix_r;
    dr = (pr > er) ? pr - er : er - pr;
    dg = (pg > eg) ? pg - eg : eg - pg;
    db = (pb > eb) ? pb - eb : eb - pb;
    d_nxt = npc_pkg::DIST_W'(dr * dr) + npc_pkg::DIST_W'(dg * dg) +
            npc_pkg::DIST_W'(db * db);
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= cnt_r;
    p2_idx_r <= p1_idx_r;
    p2_rgb_r <= ram_rdata;
    d_r      <= d_nxt;
  end

  // strictly smaller wins, so ties keep the lowest index
  assign take_best = p2_v_r && ((p2_idx_r == '0) || (d_r < best_d_r));

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_d_r   <= d_r;
      best_idx_r <= p2_idx_r;
      best_rgb_r <= p2_rgb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rgb_r <= best_rgb_r;
      out_idx_r <= best_idx_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_rgb_r[3*npc_pkg::COLOR_W-1:2*npc_pkg::COLOR_W];
  assign out_green        = out_rgb_r[2*npc_pkg::COLOR_W-1:npc_pkg::COLOR_W];
  assign out_blue         = out_rgb_r[npc_pkg::COLOR_W-1:0];
  assign out_chosen_index = out_idx_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    p2_v_r |-> (p2_idx_r <= last_r))
    else $error("scanned entry beyond search count");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!p1_v_r && !p2_v_r))
    else $error("read pipe busy while idle");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !ram_we)
    else $error("palette written during a scan");

  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DRAIN))
    else $error("result without a finished scan");

endmodule

`default_nettype wire

// ===== design/nearest_palette_color.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color
// maps an rgb pixel to the nearest loaded palette entry by squared distance
// ----------------------------------------------------------------------------
// path: a write item passes the queue and is written by the idle back end; a
//   map item scans entries 0 to n - 1, then drains the read pipe before its
//   result is loaded, n being the clamped active_entries count (1 to 256)
// throughput: one map scan at a time, bound by the single palette read port
//   (one entry per cycle); one write per cycle while the back end is idle
// reset: active_entries returns to 256, queue and output empty; palette
//   contents stay undefined until written, no clearing pass
`default_nettype none

module nearest_palette_color (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [npc_pkg::IDX_W-1:0]      in_entry_index,
  input  wire logic [npc_pkg::COLOR_W-1:0]    in_red,
  input  wire logic [npc_pkg::COLOR_W-1:0]    in_green,
  input  wire logic [npc_pkg::COLOR_W-1:0]    in_blue,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [npc_pkg::COLOR_W-1:0]         out_red,
  output logic [npc_pkg::COLOR_W-1:0]         out_green,
  output logic [npc_pkg::COLOR_W-1:0]         out_blue,
  output logic [npc_pkg::IDX_W-1:0]           out_chosen_index,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [npc_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic      [31:0]                    cfg_prdata,
  output logic                                cfg_pready
);

  logic            q_push;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;
  npc_pkg::item_t  push_item;
  npc_pkg::item_t  head_item;

  assign cfg_pready = 1'b1;

  npc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .q_push         (q_push),
    .q_item         (push_item),
    .q_ready        (q_ready)
  );

  npc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .ready      (q_ready),
    .head_valid (q_valid),
    .head_item  (head_item),
    .pop        (q_pop)
  );

  npc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (head_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_chosen_index (out_chosen_index)
  );

endmodule

`default_nettype wire
